FILE: rtl/assert_macros.svh
// assertion macros shared by the frame builder modules
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed: same-cycle implication");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed: next-cycle implication");

`endif

FILE: rtl/cfcb_pkg.sv
// shared types, byte positions and crc helper for the command frame builder
// no dependencies
package cfcb_pkg;

    localparam int unsigned IDX_W = 4;
    typedef logic [IDX_W-1:0] t_idx;

    // byte positions inside one frame
    localparam t_idx IDX_HEAD   = 4'd0;
    localparam t_idx IDX_CMD    = 4'd1;
    localparam t_idx IDX_SPD_LO = 4'd2;
    localparam t_idx IDX_SPD_HI = 4'd3;
    localparam t_idx IDX_ANG_LO = 4'd4;
    localparam t_idx IDX_ANG_HI = 4'd5;
    localparam t_idx IDX_CRC0   = 4'd6;
    localparam t_idx IDX_CRC1   = 4'd7;
    localparam t_idx IDX_CRC2   = 4'd8;
    localparam t_idx IDX_CRC3   = 4'd9;
    localparam t_idx IDX_TAIL   = 4'd10;

    // configuration register indexes
    localparam logic CFG_HEAD = 1'b0;
    localparam logic CFG_TAIL = 1'b1;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [7:0]  tail;
        logic [15:0] angle;
        logic [15:0] speed;
        logic [7:0]  cmd;
        logic [7:0]  head;
    } t_frame_req;

    // one byte of reflected crc-32, bit at a time
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                               input logic [7:0]  data);
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int b = 0; b < 8; b++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

FILE: rtl/cfcb_front.sv
// front end: configuration registers and command intake
// depends on cfcb_pkg; feeds cfcb_queue
module cfcb_front
    import cfcb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,
    output logic        o_q_valid,
    input  logic        i_q_ready,
    output t_frame_req  o_q_item
);

    logic [7:0] r_head, n_head;
    logic [7:0] r_tail, n_tail;

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HEAD: n_head = i_cfg_data;
                CFG_TAIL: n_tail = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= 8'd0;
            r_tail <= 8'd0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
        end
    end

    // markers are bound to the command when it enters the queue
    always_comb begin
        o_q_item.head  = r_head;
        o_q_item.cmd   = i_s_axis_tdata[7:0];
        o_q_item.speed = i_s_axis_tdata[23:8];
        o_q_item.angle = i_s_axis_tdata[39:24];
        o_q_item.tail  = r_tail;
    end

    assign o_q_valid       = i_s_axis_tvalid;
    assign o_s_axis_tready = i_q_ready;

endmodule

FILE: rtl/cfcb_queue.sv
// small register queue between intake and serializer
// depends on cfcb_pkg and assert_macros.svh
`include "assert_macros.svh"
module cfcb_queue
    import cfcb_pkg::*;
#(
    parameter int unsigned DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push_valid,
    output logic       o_push_ready,
    input  t_frame_req i_push_item,
    output logic       o_pop_valid,
    input  logic       i_pop_ready,
    output t_frame_req o_pop_item
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_frame_req       r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             push, pop;

    assign o_push_ready = (r_count != CNT_FULL);
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    `ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_FULL)
    `ASSERT_NEXT(a_push_grows, i_clk, i_rst_n, push && !pop, r_count == $past(r_count) + 1'b1)
    `ASSERT_SAME(a_ptr_gap, i_clk, i_rst_n, r_count == '0, r_wr_ptr == r_rd_ptr)

endmodule

FILE: rtl/cfcb_back.sv
// back end: frame serializer with running crc-32 and output register
// depends on cfcb_pkg and assert_macros.svh; drains cfcb_queue
`include "assert_macros.svh"
module cfcb_back
    import cfcb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    output logic       o_q_ready,
    input  t_frame_req i_q_item,
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,
    output logic       o_m_axis_tlast
);

    t_frame_req  r_item, n_item;
    logic [31:0] r_crc, n_crc;
    t_idx        r_idx, n_idx;
    logic        r_busy, n_busy;
    logic        r_tvalid, n_tvalid;
    logic [7:0]  r_tdata, n_tdata;
    logic        r_tlast, n_tlast;
    logic        adv;
    logic [7:0]  cur_byte;

    // output register moves when empty or being drained
    assign adv       = !r_tvalid || i_m_axis_tready;
    assign o_q_ready = adv && !r_busy;

    always_comb begin
        case (r_idx)
            IDX_CMD:    cur_byte = r_item.cmd;
            IDX_SPD_LO: cur_byte = r_item.speed[7:0];
            IDX_SPD_HI: cur_byte = r_item.speed[15:8];
            IDX_ANG_LO: cur_byte = r_item.angle[7:0];
            IDX_ANG_HI: cur_byte = r_item.angle[15:8];
            IDX_CRC0:   cur_byte = ~r_crc[7:0];
            IDX_CRC1:   cur_byte = ~r_crc[15:8];
            IDX_CRC2:   cur_byte = ~r_crc[23:16];
            IDX_CRC3:   cur_byte = ~r_crc[31:24];
            IDX_TAIL:   cur_byte = r_item.tail;
            default:    cur_byte = r_item.head;
        endcase
    end

    always_comb begin
        n_item   = r_item;
        n_crc    = r_crc;
        n_idx    = r_idx;
        n_busy   = r_busy;
        n_tvalid = r_tvalid;
        n_tdata  = r_tdata;
        n_tlast  = r_tlast;
        if (adv) begin
            if (r_busy) begin
                n_tvalid = 1'b1;
                n_tdata  = cur_byte;
                n_tlast  = (r_idx == IDX_TAIL);
                n_idx    = r_idx + 4'd1;
                if (r_idx <= IDX_ANG_HI) begin
                    n_crc = crc32_byte(r_crc, cur_byte);
                end
                if (r_idx == IDX_TAIL) begin
                    n_busy = 1'b0;
                end
            end else if (i_q_valid) begin
                // head byte goes out straight from the queue head
                n_item   = i_q_item;
                n_tvalid = 1'b1;
                n_tdata  = i_q_item.head;
                n_tlast  = 1'b0;
                n_crc    = crc32_byte(CRC_INIT, i_q_item.head);
                n_idx    = IDX_CMD;
                n_busy   = 1'b1;
            end else begin
                n_tvalid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_idx    <= IDX_HEAD;
            r_tvalid <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_idx    <= n_idx;
            r_tvalid <= n_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item  <= n_item;
        r_crc   <= n_crc;
        r_tdata <= n_tdata;
        r_tlast <= n_tlast;
    end

    assign o_m_axis_tvalid = r_tvalid;
    assign o_m_axis_tdata  = r_tdata;
    assign o_m_axis_tlast  = r_tlast;

    `ASSERT_SAME(a_last_ends_frame, i_clk, i_rst_n, r_tvalid && r_tlast, !r_busy)
    `ASSERT_SAME(a_idx_range, i_clk, i_rst_n, r_busy, r_idx >= IDX_CMD && r_idx <= IDX_TAIL)
    `ASSERT_NEXT(a_pop_starts, i_clk, i_rst_n, i_q_valid && o_q_ready, r_busy && r_idx == IDX_CMD)
    `ASSERT_SAME(a_busy_valid, i_clk, i_rst_n, r_busy && r_idx != IDX_CMD, r_tvalid)

endmodule

FILE: rtl/crc32_command_frame_builder.sv
// Command frame builder. Each command accepted on the input stream (code,
// 16-bit speed, 16-bit angle) is sent out as an 11-byte frame, one byte per
// cycle while the sink is ready: head marker, code, speed lo/hi, angle lo/hi,
// reflected crc-32 of those six bytes (lsb first), tail marker flagged by
// tlast. Frames follow each other with no gap while commands are queued and
// the sink is ready. The first byte passes through the queue and then the
// output register before it appears. Commands wait in a QUEUE_DEPTH-entry
// queue while a frame is going out. Head and tail markers are sampled when a
// command is accepted.
module crc32_command_frame_builder
    import cfcb_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,        // 0 head_byte, 1 tail_byte
    input  logic [7:0]  i_cfg_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // command_code[7:0], speed_value[23:8],
                                          // angle_value[39:24]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // frame_byte[7:0]
    output logic        o_m_axis_tlast    // last_byte
);

    logic       push_valid, push_ready;
    t_frame_req push_item;
    logic       pop_valid, pop_ready;
    t_frame_req pop_item;

    cfcb_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_q_valid       (push_valid),
        .i_q_ready       (push_ready),
        .o_q_item        (push_item)
    );

    cfcb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_item  (push_item),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_item   (pop_item)
    );

    cfcb_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (pop_valid),
        .o_q_ready       (pop_ready),
        .i_q_item        (pop_item),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule

FILE: verif/tb_crc32_command_frame_builder.sv
// self-checking testbench for crc32_command_frame_builder: motion commands in, crc-framed bytes out
// depends on cfcb_pkg (register indexes) and the frame builder rtl
module tb_crc32_command_frame_builder;
    timeunit 1ns;
    timeprecision 1ps;

    import cfcb_pkg::*;

    localparam logic [31:0] REFL_POLY  = 32'hEDB8_8320;
    localparam int          FRAME_BYTES = 11;

    typedef struct {
        logic [7:0]  code;
        logic [15:0] speed;
        logic [15:0] angle;
        bit          hold_for_drain;
    } t_motion_cmd;

    typedef struct {
        logic [7:0] value;
        logic       last;
    } t_frame_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = 1'b0;
    logic [7:0]  i_cfg_data = 8'd0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [39:0] i_s_axis_tdata = 40'd0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [7:0]  o_m_axis_tdata;
    logic        o_m_axis_tlast;

    t_motion_cmd cmd_queue[$];
    t_frame_byte frame_bytes_due[$];
    logic [7:0]  head_marker = 8'd0;
    logic [7:0]  tail_marker = 8'd0;
    int          src_gap_pct = 29;
    int          sink_stall_pct = 86;
    int          mismatches = 0;

    crc32_command_frame_builder u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #6 i_clk = ~i_clk;

    // reflected crc-32 over the six header bytes, bit 0 of byte 0 first
    function automatic logic [31:0] crc32_of_header(input logic [47:0] msg);
        logic [31:0] r;
        r = 32'hFFFF_FFFF;
        for (int k = 0; k < 48; k++) begin
            if (r[0] ^ msg[k])
                r = (r >> 1) ^ REFL_POLY;
            else
                r = r >> 1;
        end
        return ~r;
    endfunction

    function automatic void build_frame(input t_motion_cmd c);
        logic [47:0] header;
        logic [31:0] crc;
        logic [7:0]  bytes [FRAME_BYTES];
        t_frame_byte fb;
        header = {c.angle, c.speed, c.code, head_marker};
        crc = crc32_of_header(header);
        for (int k = 0; k < 6; k++)
            bytes[k] = header[8*k +: 8];
        for (int k = 0; k < 4; k++)
            bytes[6+k] = crc[8*k +: 8];
        bytes[10] = tail_marker;
        for (int k = 0; k < FRAME_BYTES; k++) begin
            fb.value = bytes[k];
            fb.last  = (k == FRAME_BYTES - 1);
            frame_bytes_due.push_back(fb);
        end
    endfunction

    // command driver
    always @(posedge i_clk) begin
        logic presenting;
        presenting = i_s_axis_tvalid;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                build_frame(cmd_queue[0]);
                void'(cmd_queue.pop_front());
                presenting = 1'b0;
            end
            // a request that was not taken stays on the bus unchanged
            if (!presenting) begin
                if (cmd_queue.size() != 0 && $urandom_range(0, 99) >= src_gap_pct &&
                    (!cmd_queue[0].hold_for_drain || frame_bytes_due.size() == 0)) begin
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= {cmd_queue[0].angle, cmd_queue[0].speed,
                                        cmd_queue[0].code};
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // byte monitor and checker
    always @(posedge i_clk) begin
        t_frame_byte want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (frame_bytes_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected byte %02h last %0b", $realtime,
                             o_m_axis_tdata, o_m_axis_tlast);
            end else begin
                want = frame_bytes_due.pop_front();
                if (o_m_axis_tdata !== want.value || o_m_axis_tlast !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: byte exp %02h got %02h, last exp %0b got %0b",
                                 $realtime, want.value, o_m_axis_tdata, want.last,
                                 o_m_axis_tlast);
                end
            end
        end
        i_m_axis_tready <= i_rst_n && ($urandom_range(0, 99) >= sink_stall_pct);
    end

    task automatic queue_cmd(input logic [7:0] code, input logic [15:0] speed,
                             input logic [15:0] angle, input bit hold);
        t_motion_cmd c;
        c.code = code;
        c.speed = speed;
        c.angle = angle;
        c.hold_for_drain = hold;
        cmd_queue.push_back(c);
    endtask

    // mostly random values, with the field extremes mixed in
    function automatic logic [15:0] pick_value(input logic [15:0] max_val);
        int sel;
        sel = $urandom_range(0, 7);
        if (sel == 0)
            return 16'd0;
        else if (sel == 1)
            return max_val;
        else
            return 16'($urandom) & max_val;
    endfunction

    task automatic queue_random(input int count);
        for (int n = 0; n < count; n++)
            queue_cmd(8'(pick_value(16'h00FF)), pick_value(16'hFFFF), pick_value(16'hFFFF),
                      $urandom_range(0, 24) == 0);
    endtask

    task automatic wait_idle();
        do
            @(posedge i_clk);
        while (cmd_queue.size() != 0 || frame_bytes_due.size() != 0 || i_s_axis_tvalid);
        // output stage may still be settling after the last byte
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_HEAD)
            head_marker = value;
        else
            tail_marker = value;
        @(posedge i_clk);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // markers at their reset values
        src_gap_pct = 29;
        sink_stall_pct = 86;
        queue_cmd(8'h00, 16'h0000, 16'h0000, 0);
        queue_cmd(8'hFF, 16'hFFFF, 16'hFFFF, 0);
        queue_cmd(8'h00, 16'hFFFF, 16'h0000, 0);
        queue_cmd(8'hFF, 16'h0000, 16'hFFFF, 0);
        queue_cmd(8'h01, 16'h0001, 16'h8000, 0);
        queue_cmd(8'h80, 16'h8000, 16'h0001, 0);
        wait_idle();

        write_reg(CFG_HEAD, 8'hFF);
        write_reg(CFG_TAIL, 8'hFF);
        queue_cmd(8'h00, 16'h0000, 16'h0000, 0);
        queue_cmd(8'hFF, 16'hFFFF, 16'hFFFF, 0);
        queue_cmd(8'h5A, 16'h1234, 16'hABCD, 1);
        queue_cmd(8'hA5, 16'h00FF, 16'hFF00, 0);
        queue_cmd(8'h3C, 16'hFF00, 16'h00FF, 0);
        queue_cmd(8'hC3, 16'h0100, 16'h0080, 0);
        wait_idle();

        write_reg(CFG_HEAD, 8'($urandom));
        write_reg(CFG_TAIL, 8'($urandom));
        queue_random(70);
        wait_idle();

        src_gap_pct = 86;
        sink_stall_pct = 29;
        write_reg(CFG_HEAD, 8'h00);
        write_reg(CFG_TAIL, 8'hFF);
        queue_random(70);
        wait_idle();

        src_gap_pct = 0;
        sink_stall_pct = 0;
        write_reg(CFG_HEAD, 8'($urandom));
        write_reg(CFG_TAIL, 8'h00);
        queue_random(60);
        wait_idle();

        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && frame_bytes_due.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
